### src/aair_pkg.sv
// Package for the area average resize block: sequencer states and shared types.
// Used by the divider and the top level; depends on nothing.
package aair_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X1,
    ST_DIV_X2,
    ST_DIV_Y1,
    ST_DIV_Y2,
    ST_SETUP,
    ST_READ,
    ST_DIV_CH,
    ST_OUT
  } aair_state_t;

  // Request for the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [17:0] den;
  } aair_div_req_t;

  // Status from the shared divider.
  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } aair_div_rsp_t;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BPP        = 3'd4;

endpackage

### src/aair_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on aair_pkg.
module aair_div
  import aair_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  aair_div_req_t req,
  output aair_div_rsp_t rsp
);

  logic [31:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [17:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [18:0] trial;

  // One shift and subtract per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[18]) begin
        rem_nxt = trial[17:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[16:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = busy_r && (cnt_r == 6'd31);
  assign rsp.quo  = trial[18] ? {quo_r[30:0], 1'b0} : {quo_r[30:0], 1'b1};

endmodule

### src/area_average_image_resize_unit.sv
// Top level of the area average resize block: config, pixel store, sequencer.
// Depends on aair_pkg and aair_div.
//
//  Channel | Direction | Handshake        | Payload
//  in_     | into      | in_valid/in_stall | action, index, channels, request x/y
//  out_    | out of    | out_valid/out_stall | x, y, averaged channels
//  cfg_    | into      | cfg_we           | cfg_index, cfg_data
//
// A request holds in_stall high through the four window bound divisions, a setup state,
// one store read per window pixel plus a drain of the last read, one division per
// channel in use and the load of the result register, all paced by the single
// bit-serial divider and the one store read port. Reset is synchronous; the store
// is not cleared. A waiting result delays only the end of the next request.
module area_average_image_resize_unit
  import aair_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH  = 256,
  parameter int MAX_DST_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_src_index,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic [7:0]  in_ch3,
  input  logic [7:0]  in_req_x,
  input  logic [7:0]  in_req_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic [7:0]  out_ch3
);

  localparam logic [12:0] MSW = 13'(MAX_SRC_WIDTH);
  localparam logic [12:0] MSH = 13'(MAX_SRC_HEIGHT);
  localparam logic [12:0] MDW = 13'(MAX_DST_WIDTH);
  localparam logic [12:0] MDH = 13'(MAX_DST_HEIGHT);

  // Configuration registers.
  logic [8:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [2:0] bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd1;
      src_h_r <= 9'd1;
      dst_w_r <= 9'd1;
      dst_h_r <= 9'd1;
      bpp_r   <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= cfg_data;
        REG_SRC_HEIGHT: src_h_r <= cfg_data;
        REG_DST_WIDTH:  dst_w_r <= cfg_data;
        REG_DST_HEIGHT: dst_h_r <= cfg_data;
        REG_BPP:        bpp_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective sizes, clamped into their legal ranges.
  function automatic logic [12:0] clamp(input logic [8:0] v, input logic [12:0] hi);
    logic [12:0] w;
    w = {4'd0, v};
    if (w == 13'd0) return 13'd1;
    if (w > hi) return hi;
    return w;
  endfunction

  logic [12:0] sw, sh, dw, dh;
  logic [2:0]  nch;
  assign sw  = clamp(src_w_r, MSW);
  assign sh  = clamp(src_h_r, MSH);
  assign dw  = clamp(dst_w_r, MDW);
  assign dh  = clamp(dst_h_r, MDH);
  assign nch = (bpp_r == 3'd0) ? 3'd1 : ((bpp_r > 3'd4) ? 3'd4 : bpp_r);

  // Pixel store: one write port for loads, one registered read port.
  logic [31:0] store [65536];
  logic [31:0] rd_data_r;
  logic [15:0] rd_addr;
  logic        st_we;

  assign st_we = in_valid && !in_stall && (in_action == ACT_LOAD);

  always_ff @(posedge clk) begin
    if (st_we) store[in_src_index] <= {in_ch3, in_ch2, in_ch1, in_ch0};
    rd_data_r <= store[rd_addr];
  end

  // Sequencer registers.
  aair_state_t state_r, state_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [12:0] x1_r, x1_nxt, x2_r, x2_nxt, y1_r, y1_nxt, y2_r, y2_nxt;
  logic [12:0] c_r, c_nxt, r_r, r_nxt;
  logic [15:0] rowbase_r, rowbase_nxt;
  logic        pend_r, pend_nxt;
  logic        last_r, last_nxt;
  logic [25:0] sum_r [4];
  logic [25:0] sum_nxt [4];
  logic [1:0]  k_r, k_nxt;
  logic [17:0] area_r, area_nxt;
  logic [7:0]  avg_r [4];
  logic [7:0]  avg_nxt [4];
  logic        ov_r, ov_nxt;
  logic [7:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [7:0]  och_r [4];
  logic [7:0]  och_nxt [4];

  aair_div_req_t dreq;
  aair_div_rsp_t drsp;

  aair_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_stall = (state_r != ST_IDLE);

  // Next state and datapath control.
  always_comb begin
    state_nxt   = state_r;
    x_nxt = x_r; y_nxt = y_r;
    x1_nxt = x1_r; x2_nxt = x2_r; y1_nxt = y1_r; y2_nxt = y2_r;
    c_nxt = c_r; r_nxt = r_r;
    rowbase_nxt = rowbase_r;
    pend_nxt    = 1'b0;
    last_nxt    = 1'b0;
    k_nxt       = k_r;
    area_nxt    = area_r;
    ov_nxt      = ov_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    for (int i = 0; i < 4; i++) begin
      sum_nxt[i] = sum_r[i];
      avg_nxt[i] = avg_r[i];
      och_nxt[i] = och_r[i];
    end
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = {5'd0, dw};
    rd_addr    = rowbase_r + c_r[15:0];

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall && in_action == ACT_REQUEST) begin
          if ({5'd0, in_req_x} < dw && {5'd0, in_req_y} < dh) begin
            x_nxt      = in_req_x;
            y_nxt      = in_req_y;
            dreq.start = 1'b1;
            dreq.num   = 32'({5'd0, in_req_x} * sw);
            dreq.den   = {5'd0, dw};
            state_nxt  = ST_DIV_X1;
          end
        end
      end
      ST_DIV_X1: if (drsp.done) begin
        x1_nxt     = drsp.quo[12:0];
        dreq.start = 1'b1;
        dreq.num   = 32'(({5'd0, x_r} + 13'd1) * sw);
        dreq.den   = {5'd0, dw};
        state_nxt  = ST_DIV_X2;
      end
      ST_DIV_X2: if (drsp.done) begin
        x2_nxt     = drsp.quo[12:0];
        dreq.start = 1'b1;
        dreq.num   = 32'({5'd0, y_r} * sh);
        dreq.den   = {5'd0, dh};
        state_nxt  = ST_DIV_Y1;
      end
      ST_DIV_Y1: if (drsp.done) begin
        y1_nxt     = drsp.quo[12:0];
        dreq.start = 1'b1;
        dreq.num   = 32'(({5'd0, y_r} + 13'd1) * sh);
        dreq.den   = {5'd0, dh};
        state_nxt  = ST_DIV_Y2;
      end
      ST_DIV_Y2: if (drsp.done) begin
        y2_nxt    = drsp.quo[12:0];
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        // Widen empty spans to one pixel and start the window walk.
        if (x1_r == x2_r) x2_nxt = x1_r + 13'd1;
        if (y1_r == y2_r) y2_nxt = y1_r + 13'd1;
        c_nxt       = x1_r;
        r_nxt       = y1_r;
        rowbase_nxt = 16'(y1_r * sw);
        for (int i = 0; i < 4; i++) sum_nxt[i] = '0;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        // Issue one read per cycle; accumulate the word read last cycle.
        if (pend_r) begin
          for (int i = 0; i < 4; i++)
            sum_nxt[i] = sum_r[i] + {18'd0, rd_data_r[8*i +: 8]};
        end
        if (last_r) begin
          area_nxt   = 18'((x2_r - x1_r) * (y2_r - y1_r));
          k_nxt      = 2'd0;
          dreq.start = 1'b1;
          dreq.num   = {6'd0, sum_nxt[0]};
          dreq.den   = 18'((x2_r - x1_r) * (y2_r - y1_r));
          state_nxt  = ST_DIV_CH;
        end else begin
          pend_nxt = 1'b1;
          if (c_r + 13'd1 == x2_r) begin
            c_nxt = x1_r;
            r_nxt = r_r + 13'd1;
            rowbase_nxt = rowbase_r + sw[15:0];
            if (r_r + 13'd1 == y2_r) last_nxt = 1'b1;
          end else begin
            c_nxt = c_r + 13'd1;
          end
        end
      end
      ST_DIV_CH: begin
        dreq.den = area_r;
        if (drsp.done) begin
          avg_nxt[k_r] = drsp.quo[7:0];
          if ({1'b0, k_r} + 3'd1 >= nch) begin
            for (int i = 0; i < 4; i++)
              if (i >= int'(nch)) avg_nxt[i] = '0;
            state_nxt = ST_OUT;
          end else begin
            k_nxt      = k_r + 2'd1;
            dreq.start = 1'b1;
            dreq.num   = {6'd0, sum_r[k_r + 2'd1]};
          end
        end
      end
      ST_OUT: begin
        // Load the result register once it is free or its transfer happens now.
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ox_nxt    = x_r;
          oy_nxt    = y_r;
          for (int i = 0; i < 4; i++) och_nxt[i] = avg_r[i];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      last_r  <= last_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt;
    x1_r <= x1_nxt; x2_r <= x2_nxt; y1_r <= y1_nxt; y2_r <= y2_nxt;
    c_r <= c_nxt; r_r <= r_nxt;
    rowbase_r <= rowbase_nxt;
    k_r <= k_nxt;
    area_r <= area_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    for (int i = 0; i < 4; i++) begin
      sum_r[i] <= sum_nxt[i];
      avg_r[i] <= avg_nxt[i];
      och_r[i] <= och_nxt[i];
    end
  end

  assign out_valid = ov_r;
  assign out_x   = ox_r;
  assign out_y   = oy_r;
  assign out_ch0 = och_r[0];
  assign out_ch1 = och_r[1];
  assign out_ch2 = och_r[2];
  assign out_ch3 = och_r[3];

endmodule

### sim/area_average_image_resize_checker.sv
// Checker for the area average resize block: watches the register port and both channels,
// predicts each averaged pixel from its own copy of the pixel store, and compares.
// Depends on aair_pkg.
module area_average_image_resize_checker
  import aair_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH  = 256,
  parameter int MAX_DST_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_src_index,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic [7:0]  in_ch3,
  input  logic [7:0]  in_req_x,
  input  logic [7:0]  in_req_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_x,
  input  logic [7:0]  out_y,
  input  logic [7:0]  out_ch0,
  input  logic [7:0]  out_ch1,
  input  logic [7:0]  out_ch2,
  input  logic [7:0]  out_ch3,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] ch [4];
  } resized_pixel_t;

  logic [31:0]    pixel_store [65536];
  logic [8:0]     src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [2:0]     bpp_reg;
  resized_pixel_t expected_pixels [$];

  initial fail_count = 0;
  initial pending = 0;

  // Sizes out of range act as the nearest legal value.
  function automatic int clamp_range(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Averages the source window behind destination pixel (x, y); returns 0 when ignored.
  function automatic bit average_window(logic [7:0] x, logic [7:0] y,
                                        output resized_pixel_t px);
    int sw, sh, dw, dh, nch, x1, x2, y1, y2, area;
    int sum [4];
    logic [31:0] word;
    sw  = clamp_range(src_w_reg, 1, MAX_SRC_WIDTH);
    sh  = clamp_range(src_h_reg, 1, MAX_SRC_HEIGHT);
    dw  = clamp_range(dst_w_reg, 1, MAX_DST_WIDTH);
    dh  = clamp_range(dst_h_reg, 1, MAX_DST_HEIGHT);
    nch = clamp_range(bpp_reg, 1, 4);
    if (x >= dw || y >= dh) return 0;
    x1 = x * sw / dw;
    x2 = (x + 1) * sw / dw;
    y1 = y * sh / dh;
    y2 = (y + 1) * sh / dh;
    if (x1 == x2) x2 = x1 + 1;
    if (y1 == y2) y2 = y1 + 1;
    sum = '{0, 0, 0, 0};
    for (int r = y1; r < y2; r++) begin
      for (int c = x1; c < x2; c++) begin
        word = pixel_store[(r * sw + c) & 16'hFFFF];
        for (int k = 0; k < nch; k++) sum[k] += word[8*k +: 8];
      end
    end
    area = (x2 - x1) * (y2 - y1);
    px.x = x;
    px.y = y;
    for (int k = 0; k < 4; k++) px.ch[k] = (k < nch) ? 8'(sum[k] / area) : 8'd0;
    return 1;
  endfunction

  // Follow register writes, input transfers and result transfers at each edge.
  always @(posedge clk) begin
    resized_pixel_t px, want;
    logic [7:0] got [4];
    if (!rst_n) begin
      src_w_reg <= 9'd1;
      src_h_reg <= 9'd1;
      dst_w_reg <= 9'd1;
      dst_h_reg <= 9'd1;
      bpp_reg   <= 3'd3;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w_reg <= cfg_data;
          REG_SRC_HEIGHT: src_h_reg <= cfg_data;
          REG_DST_WIDTH:  dst_w_reg <= cfg_data;
          REG_DST_HEIGHT: dst_h_reg <= cfg_data;
          REG_BPP:        bpp_reg   <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_LOAD)
          pixel_store[in_src_index] = {in_ch3, in_ch2, in_ch1, in_ch0};
        else if (average_window(in_req_x, in_req_y, px))
          expected_pixels.push_back(px);
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transfer at x=%0d y=%0d", out_x, out_y);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          got = '{out_ch0, out_ch1, out_ch2, out_ch3};
          if (out_x !== want.x) begin
            $error("out_x expected %0d actual %0d", want.x, out_x);
            fail_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y expected %0d actual %0d", want.y, out_y);
            fail_count++;
          end
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want.ch[k]) begin
              $error("out_ch%0d expected %0d actual %0d", k, want.ch[k], got[k]);
              fail_count++;
            end
          end
        end
      end
      pending = expected_pixels.size();
    end
  end

endmodule

### sim/testbench.sv
// Top of the resize testbench: clock, reset, register setup, load and request stimulus.
// Depends on aair_pkg, area_average_image_resize_unit and area_average_image_resize_checker.
module testbench;
  import aair_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QUIET_CYCLES   = 400;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam logic [2:0]  REG_SPARE      = 3'd5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_LOAD;
  logic [15:0] in_src_index = '0;
  logic [7:0]  in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic [7:0]  in_req_x = '0, in_req_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_x, out_y, out_ch0, out_ch1, out_ch2, out_ch3;
  int          fail_count, pending;

  // Effective sizes of the current setting and which store entries hold a pixel.
  int eff_sw = 1, eff_sh = 1, eff_dw = 1, eff_dh = 1;
  bit loaded [65536];
  bit no_gaps = 0;
  bit stalls_on = 1;
  int idle_cycles = 0;

  area_average_image_resize_unit u_dut (.*);

  area_average_image_resize_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Random receiver stalls in runs of mostly short and a few long lengths.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        out_stall = stalls_on && ($urandom_range(0, 2) == 0);
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
    end
  end

  // Watchdog: ends the run when nothing has been transferred for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int clamp_range(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one item and holds it until the transfer happens.
  task automatic send_item(logic act, logic [15:0] idx, logic [31:0] chans,
                           logic [7:0] x, logic [7:0] y);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_src_index = idx;
    {in_ch3, in_ch2, in_ch1, in_ch0} = chans;
    in_req_x = x;
    in_req_y = y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_pixel(int idx, logic [31:0] chans);
    send_item(ACT_LOAD, 16'(idx), chans, 8'($urandom), 8'($urandom));
    loaded[idx] = 1;
  endtask

  // Requests a destination pixel, first loading any pixel of its window not yet loaded.
  task automatic request_pixel(int x, int y);
    int x1, x2, y1, y2;
    if (x < eff_dw && y < eff_dh) begin
      x1 = x * eff_sw / eff_dw;
      x2 = (x + 1) * eff_sw / eff_dw;
      y1 = y * eff_sh / eff_dh;
      y2 = (y + 1) * eff_sh / eff_dh;
      if (x1 == x2) x2 = x1 + 1;
      if (y1 == y2) y2 = y1 + 1;
      for (int r = y1; r < y2; r++)
        for (int c = x1; c < x2; c++)
          if (!loaded[r * eff_sw + c]) load_pixel(r * eff_sw + c, $urandom);
    end
    send_item(ACT_REQUEST, 16'($urandom), $urandom, 8'(x), 8'(y));
  endtask

  // Lets the block drain, including work on requests that give no result.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // New image sizes: the store keeps its contents, so the loaded map is cleared.
  task automatic set_sizes(int sw, int sh, int dw, int dh, int bpp);
    wait_idle();
    write_reg(REG_SRC_WIDTH, 9'(sw));
    write_reg(REG_SRC_HEIGHT, 9'(sh));
    write_reg(REG_DST_WIDTH, 9'(dw));
    write_reg(REG_DST_HEIGHT, 9'(dh));
    write_reg(REG_BPP, 9'(bpp));
    if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(REG_SPARE, 7)), 9'($urandom));
    eff_sw = clamp_range(sw, 1, 256);
    eff_sh = clamp_range(sh, 1, 256);
    eff_dw = clamp_range(dw, 1, 256);
    eff_dh = clamp_range(dh, 1, 256);
    loaded = '{default: 0};
  endtask

  // Mostly in-range requests, with loads and requests that fall outside the destination.
  task automatic random_items(int count, bit pause_midway);
    int r;
    no_gaps = ($urandom_range(0, 3) == 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 15)
        load_pixel($urandom_range(0, eff_sw * eff_sh - 1), $urandom);
      else if (r < 20)
        load_pixel($urandom_range(0, 65535), $urandom);
      else if (r < 90)
        request_pixel($urandom_range(0, eff_dw - 1), $urandom_range(0, eff_dh - 1));
      else
        request_pixel($urandom_range(eff_dw, 255 + (eff_dw == 256)) % 256,
                      $urandom_range(0, 255));
    end
  endtask

  initial begin
    int sw, sh;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part under the reset setting: extreme bytes and a request outside.
    load_pixel(0, 32'hFFFF_FFFF);
    request_pixel(0, 0);
    request_pixel(1, 0);
    request_pixel(0, 1);
    load_pixel(65535, 32'h0000_0000);
    load_pixel(0, 32'h5A_A5_00_FF);
    request_pixel(0, 0);

    // Zero sizes act as one, and a zero channel count as one channel.
    set_sizes(0, 0, 0, 0, 0);
    write_reg(REG_SPARE, 9'h1FF);
    request_pixel(0, 0);

    // Oversized registers saturate: widest source and destination with four channels.
    set_sizes(300, 2, 511, 3, 7);
    request_pixel(255, 2);
    request_pixel(0, 0);
    request_pixel(0, 3);
    request_pixel(255, 255);

    // Whole source row averaged into one pixel, then a tall column.
    set_sizes(256, 1, 1, 1, 4);
    request_pixel(0, 0);
    set_sizes(1, 256, 1, 256, 2);
    request_pixel(0, 255);
    request_pixel(0, 0);

    // Random settings: mostly small images, with the extremes now and then.
    for (int p = 0; p < 10; p++) begin
      sw = ($urandom_range(0, 5) == 0) ? 256 : $urandom_range(1, 24);
      sh = (sw == 256) ? $urandom_range(1, 2) : $urandom_range(1, 24);
      set_sizes(sw, sh, $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 7));
      random_items(40, p == 3);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
